// ----- sv/wpca_pkg.sv -----
package wpca_pkg;

  // Field widths.
  localparam int unsigned IdxW   = 20;
  localparam int unsigned BeginW = 20;
  localparam int unsigned EndW   = 21;
  localparam int unsigned CountW = 21;
  localparam int unsigned SigmaW = 32;
  localparam int unsigned GenoW  = 16;
  localparam int unsigned LoadW  = 16;
  localparam int unsigned ScoreW = 32;

  // Datapath widths.
  localparam int unsigned ProdW  = GenoW + LoadW;       // genotype times loading
  localparam int unsigned AccW   = 52;                  // Q24.27 accumulator
  localparam int unsigned CntSh  = 5;                   // marker_count scaled by 32
  localparam int unsigned HalfW  = AccW / 2;            // magnitude half for split multiply
  localparam int unsigned CntShW = CountW + CntSh;
  localparam int unsigned MulW   = 33;                  // shared signed multiplier operand
  localparam int unsigned MulPW  = 2 * MulW;
  localparam int unsigned DenW   = EndW + SigmaW;
  localparam int unsigned NumW   = AccW + CntShW;

  // Reset values of the configuration registers.
  localparam logic [BeginW-1:0] BeginReset = '0;
  localparam logic [EndW-1:0]   EndReset   = 21'h10_0000;
  localparam logic [CountW-1:0] CountReset = 21'h10_0000;
  localparam logic [SigmaW-1:0] SigmaReset = 32'h0001_0000;

  // Register indexes.
  localparam int unsigned RegWinBegin  = 0;
  localparam int unsigned RegWinEnd    = 1;
  localparam int unsigned RegCount     = 2;
  localparam int unsigned RegSigmaBase = 3;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StEmpty     = 2'd1,
    StZeroSigma = 2'd2,
    StSat       = 2'd3
  } status_e;

endpackage

// ----- sv/wpca_in_if.sv -----
interface wpca_in_if import wpca_pkg::*; #(parameter int unsigned LANES = 4);
  logic                     valid;
  logic                     ready;
  logic [IdxW-1:0]          marker_index;
  logic signed [GenoW-1:0]  genotype;
  logic [LANES*LoadW-1:0]   loading;
  logic                     last_marker;

  modport source (output valid, marker_index, genotype, loading, last_marker, input ready);
  modport sink   (input valid, marker_index, genotype, loading, last_marker, output ready);
endinterface

// ----- sv/wpca_out_if.sv -----
interface wpca_out_if import wpca_pkg::*; #(parameter int unsigned LANES = 4);
  logic                    valid;
  logic                    ready;
  logic [LANES*ScoreW-1:0] score;
  status_e                 status;

  modport source (output valid, score, status, input ready);
  modport sink   (input valid, score, status, output ready);
endinterface

// ----- sv/wpca_mul.sv -----
module wpca_mul import wpca_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [MulPW-1:0] p_o
);

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- sv/wpca_div.sv -----
module wpca_div import wpca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [DenW-1:0]   den_i,
  input  logic              neg_i,
  output logic              done_o,
  output logic [ScoreW-1:0] result_o,
  output logic              sat_o
);

  localparam int unsigned StepW = $clog2(NumW);

  logic [NumW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [DenW-1:0]   rem_q;
  logic [ScoreW:0]   quo_q;
  logic              big_q;
  logic              neg_q;
  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;

  logic [DenW:0]     rem_sh;
  logic [DenW:0]     rem_sub;
  logic              ge;
  logic [ScoreW:0]   limit;
  logic [ScoreW-1:0] mag;

  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      big_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(NumW - 1);
        num_q  <= num_i;
        den_q  <= den_i;
        neg_q  <= neg_i;
        rem_q  <= '0;
        quo_q  <= '0;
        big_q  <= 1'b0;
      end else if (busy_q) begin
        num_q  <= {num_q[NumW-2:0], 1'b0};
        rem_q  <= ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
        // A quotient bit pushed past the top means the result cannot fit.
        big_q  <= big_q | quo_q[ScoreW];
        quo_q  <= {quo_q[ScoreW-1:0], ge};
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
    end
  end

  // Negative results may reach 2^31, positive ones stop at 2^31 - 1.
  assign limit    = {1'b0, neg_q, {(ScoreW-1){~neg_q}}};
  assign sat_o    = big_q || (quo_q > limit);
  assign mag      = sat_o ? limit[ScoreW-1:0] : quo_q[ScoreW-1:0];
  assign result_o = neg_q ? (ScoreW'(0) - mag) : mag;
  assign done_o   = done_q;

endmodule

// ----- sv/windowed_pca_score_projection.sv -----
// Channel   Dir  Handshake      Payload
// marker_i  in   valid/ready    marker_index, genotype, loading[LANES], last_marker
// score_o   out  valid/ready    score[LANES], status
// cfg       in   cfg_we_i       cfg_index_i, cfg_data_i (write only)
//
// A marker inside the window runs one MAC step per lane on the shared multiplier
// and then MAC_END; one outside it is taken in IDLE alone. A last marker adds CHECK,
// per lane DEN, NLO, NHI, NADD and the serial divider, and FIN to load the result.
// Reset clears the accumulators and restores the register defaults.
// marker_i.ready is high only while the sequencer is idle; a pending result
// stalls the block only when the next result is ready to be loaded.
module windowed_pca_score_projection import wpca_pkg::*; #(
  parameter int unsigned LANES = 4,
  localparam int unsigned CfgIdxW = $clog2(RegSigmaBase + LANES),
  localparam int unsigned LaneW   = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wpca_in_if.sink            marker_i,
  wpca_out_if.source         score_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SigmaW-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    IDLE, MAC, MAC_END, CHECK, DEN, NLO, NHI, NADD, DIV, FIN
  } state_e;

  // Configuration registers.
  logic [BeginW-1:0] begin_q;
  logic [EndW-1:0]   end_q;
  logic [CountW-1:0] count_q;
  logic [SigmaW-1:0] sigma_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= BeginReset;
      end_q   <= EndReset;
      count_q <= CountReset;
      for (int k = 0; k < LANES; k++) begin
        sigma_q[k] <= SigmaReset;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgIdxW'(RegWinBegin)) begin
        begin_q <= cfg_data_i[BeginW-1:0];
      end
      if (cfg_index_i == CfgIdxW'(RegWinEnd)) begin
        end_q <= cfg_data_i[EndW-1:0];
      end
      if (cfg_index_i == CfgIdxW'(RegCount)) begin
        count_q <= cfg_data_i[CountW-1:0];
      end
      for (int k = 0; k < LANES; k++) begin
        if (cfg_index_i == CfgIdxW'(RegSigmaBase + k)) begin
          sigma_q[k] <= cfg_data_i;
        end
      end
    end
  end

  state_e                   state_q;
  logic [LaneW-1:0]         lane_q;
  logic                     add_v_q;
  logic [LaneW-1:0]         add_lane_q;
  logic [AccW-1:0]          acc_q [LANES];
  logic signed [GenoW-1:0]  geno_q;
  logic [LANES*LoadW-1:0]   load_q;
  logic                     last_q;
  logic                     neg_q;
  logic [AccW-1:0]          mag_q;
  logic [DenW-1:0]          den_q;
  logic [NumW-1:0]          num_q;
  logic                     div_start_q;
  logic [ScoreW-1:0]        score_q [LANES];
  status_e                  status_q;
  logic                     out_valid_q;
  logic [LANES*ScoreW-1:0]  out_score_q;
  status_e                  out_status_q;

  logic                     in_win;
  logic                     sigma_zero;
  logic                     acc_zero;
  logic                     fin_go;
  logic [EndW-1:0]          win_w;
  logic [CntShW-1:0]        cnt_sh;
  logic [AccW-1:0]          acc_sel;
  logic [LoadW-1:0]         load_sel;
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic                     div_done;
  logic [ScoreW-1:0]        div_result;
  logic                     div_sat;

  assign in_win = (marker_i.marker_index >= begin_q) &&
                  ({1'b0, marker_i.marker_index} < end_q);
  assign win_w    = end_q - {1'b0, begin_q};
  assign cnt_sh   = {count_q, CntSh'(0)};
  assign acc_sel  = acc_q[lane_q];
  assign load_sel = load_q[lane_q*LoadW +: LoadW];
  assign fin_go   = !out_valid_q || score_o.ready;

  always_comb begin
    sigma_zero = 1'b0;
    acc_zero   = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      sigma_zero = sigma_zero | (sigma_q[k] == '0);
      acc_zero   = acc_zero & (acc_q[k] == '0);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      MAC: begin
        mul_a = {{(MulW-GenoW){geno_q[GenoW-1]}}, geno_q};
        mul_b = {{(MulW-LoadW){load_sel[LoadW-1]}}, load_sel};
      end
      DEN: begin
        mul_a = {{(MulW-EndW){1'b0}}, win_w};
        mul_b = {{(MulW-SigmaW){1'b0}}, sigma_q[lane_q]};
      end
      NLO: begin
        mul_a = {{(MulW-HalfW){1'b0}}, mag_q[HalfW-1:0]};
        mul_b = {{(MulW-CntShW){1'b0}}, cnt_sh};
      end
      NHI: begin
        mul_a = {{(MulW-HalfW){1'b0}}, mag_q[AccW-1:HalfW]};
        mul_b = {{(MulW-CntShW){1'b0}}, cnt_sh};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wpca_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wpca_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start_q),
    .num_i    (num_q),
    .den_i    (den_q),
    .neg_i    (neg_q),
    .done_o   (div_done),
    .result_o (div_result),
    .sat_o    (div_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      lane_q       <= '0;
      add_v_q      <= 1'b0;
      add_lane_q   <= '0;
      geno_q       <= '0;
      load_q       <= '0;
      last_q       <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      den_q        <= '0;
      num_q        <= '0;
      div_start_q  <= 1'b0;
      status_q     <= StOk;
      out_valid_q  <= 1'b0;
      out_score_q  <= '0;
      out_status_q <= StOk;
      for (int k = 0; k < LANES; k++) begin
        acc_q[k]   <= '0;
        score_q[k] <= '0;
      end
    end else begin
      // The product issued in the previous cycle lands in its lane here.
      add_v_q     <= (state_q == MAC);
      add_lane_q  <= lane_q;
      div_start_q <= 1'b0;
      if (add_v_q) begin
        acc_q[add_lane_q] <= acc_q[add_lane_q] +
                             {{(AccW-ProdW){mul_p[ProdW-1]}}, mul_p[ProdW-1:0]};
      end
      if (state_q == FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && score_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (marker_i.valid) begin
            geno_q <= marker_i.genotype;
            load_q <= marker_i.loading;
            last_q <= marker_i.last_marker;
            lane_q <= '0;
            if (in_win) begin
              state_q <= MAC;
            end else if (marker_i.last_marker) begin
              state_q <= CHECK;
            end
          end
        end
        MAC: begin
          if (lane_q == LaneW'(LANES - 1)) begin
            state_q <= MAC_END;
          end else begin
            lane_q <= lane_q + LaneW'(1);
          end
        end
        MAC_END: begin
          state_q <= last_q ? CHECK : IDLE;
        end
        CHECK: begin
          lane_q <= '0;
          for (int k = 0; k < LANES; k++) begin
            score_q[k] <= '0;
          end
          if (end_q <= {1'b0, begin_q}) begin
            status_q <= StEmpty;
            state_q  <= FIN;
          end else if (sigma_zero) begin
            status_q <= StZeroSigma;
            state_q  <= FIN;
          end else begin
            status_q <= StOk;
            state_q  <= DEN;
          end
        end
        DEN: begin
          neg_q   <= acc_sel[AccW-1];
          mag_q   <= acc_sel[AccW-1] ? (AccW'(0) - acc_sel) : acc_sel;
          state_q <= NLO;
        end
        NLO: begin
          den_q   <= mul_p[DenW-1:0];
          state_q <= NHI;
        end
        NHI: begin
          num_q   <= {{(NumW-2*HalfW){1'b0}}, mul_p[2*HalfW-1:0]};
          state_q <= NADD;
        end
        NADD: begin
          num_q       <= num_q + {mul_p[NumW-HalfW-1:0], HalfW'(0)};
          div_start_q <= 1'b1;
          state_q     <= DIV;
        end
        DIV: begin
          if (div_done) begin
            score_q[lane_q] <= div_result;
            if (div_sat) begin
              status_q <= StSat;
            end
            if (lane_q == LaneW'(LANES - 1)) begin
              state_q <= FIN;
            end else begin
              lane_q  <= lane_q + LaneW'(1);
              state_q <= DEN;
            end
          end
        end
        FIN: begin
          if (fin_go) begin
            out_status_q <= status_q;
            for (int k = 0; k < LANES; k++) begin
              out_score_q[k*ScoreW +: ScoreW] <= score_q[k];
              acc_q[k] <= '0;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign marker_i.ready = (state_q == IDLE);
  assign score_o.valid  = out_valid_q;
  assign score_o.score  = out_score_q;
  assign score_o.status = out_status_q;

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == FIN)
    else $error("result appeared without a finished scaling pass");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FIN && fin_go) |=> acc_zero)
    else $error("accumulators not cleared after a result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StEmpty) |-> out_score_q == '0)
    else $error("empty window result carries nonzero scores");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> den_q != '0)
    else $error("divider started with a zero divisor");

endmodule
